FILE: hdl/rsdz_pkg.sv
// ----------------------------------------------------------------------------
// rsdz_pkg
// Shared types and constants for the radial stick dead-zone block.
// ----------------------------------------------------------------------------
package rsdz_pkg;

  // Largest magnitude used for the rescale.
  localparam logic [14:0] FULL_SCALE = 15'h7FFF;
  // Dead-zone radius after reset.
  localparam logic [14:0] DZ_RESET   = 15'd7849;
  // Saturation limits of a signed 16-bit axis.
  localparam logic signed [15:0] AXIS_MAX = 16'sh7FFF;
  localparam logic signed [15:0] AXIS_MIN = 16'sh8000;
  // Register index decoded from paddr[2].
  localparam logic REG_DEAD_ZONE = 1'b0;

  // One stick sample.
  typedef struct packed {
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
  } in_t;

  // One rescaled result.
  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic               in_dead_zone;
  } out_t;

endpackage

FILE: hdl/radial_stick_dead_zone_top.sv
// ----------------------------------------------------------------------------
// radial_stick_dead_zone_top
// Scaled radial dead zone for one thumbstick sample per beat.
// ----------------------------------------------------------------------------
// Usage:
//   A sample beat (in_data) is taken on every clock edge with start high;
//   busy is always low, so a new sample may enter every cycle.
//   Each sample gives one result beat on out_data, marked by out_valid for
//   exactly one cycle; the receiver cannot stall and must take it then.
//   Samples pass the input and sum registers, the 16-stage square root,
//   the operand register, the one-bit-per-stage scale divider, the product
//   register, the axis dividers and the output register, one sample per cycle.
//   The dead-zone radius is written over the APB port at byte address 0
//   and read back there; write it only while no sample is in flight.
//   Reset clears all valid bits, so no result appears until new samples
//   enter, and sets the radius to 7849.
// ----------------------------------------------------------------------------
module radial_stick_dead_zone_top
  import rsdz_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  // Sample channel
  input  logic        start,
  output logic        busy,
  input  in_t         in_data,
  // Result channel
  output logic        out_valid,
  output out_t        out_data,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int QW  = OUT_FRAC_BITS + 1;
  localparam int PW  = 16 + QW;
  localparam int LAT = 21 + 2 * QW;

  // Configuration register.
  logic [14:0] dz_r;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign prdata = (paddr[2] == REG_DEAD_ZONE) ? {17'd0, dz_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r <= DZ_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_DEAD_ZONE)) begin
      dz_r <= pwdata[14:0];
    end
  end

  // Input register.
  logic        s0_v_r;
  in_t         s0_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= start;
    end
    s0_d_r <= in_data;
  end

  // Sum of squares.
  logic        s1_v_r;
  logic [31:0] s1_sum_r;
  in_t         s1_d_r;
  logic [31:0] sum_nxt;

  assign sum_nxt = 32'(s0_d_r.stick_x * s0_d_r.stick_x) +
                   32'(s0_d_r.stick_y * s0_d_r.stick_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s0_v_r;
    end
    s1_sum_r <= sum_nxt;
    s1_d_r   <= s0_d_r;
  end

  // Magnitude.
  logic        sq_v;
  logic [15:0] sq_mag;
  in_t         sq_d;

  rsdz_isqrt #(.SW(32)) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_v_r),
    .in_rad    (s1_sum_r),
    .in_side   (s1_d_r),
    .out_valid (sq_v),
    .out_root  (sq_mag),
    .out_side  (sq_d)
  );

  // Dead-zone test and scale operands.
  logic        sm_v_r;
  logic        sm_dz_r;
  logic [14:0] sm_n_r;
  logic [14:0] sm_den_r;
  logic [15:0] sm_mag_r;
  in_t         sm_d_r;
  logic [14:0] mc;
  logic [14:0] n_nxt;
  logic [14:0] den_nxt;

  always_comb begin
    mc      = (sq_mag > {1'b0, FULL_SCALE}) ? FULL_SCALE : sq_mag[14:0];
    n_nxt   = (mc > dz_r) ? 15'(mc - dz_r) : 15'd0;
    den_nxt = 15'(FULL_SCALE - dz_r);
    // A zero divisor only comes with a zero numerator; divide by one then.
    if (den_nxt == 15'd0) begin
      den_nxt = 15'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm_v_r <= 1'b0;
    end else begin
      sm_v_r <= sq_v;
    end
    sm_dz_r  <= (sq_mag <= {1'b0, dz_r});
    sm_n_r   <= n_nxt;
    sm_den_r <= den_nxt;
    sm_mag_r <= sq_mag;
    sm_d_r   <= sq_d;
  end

  // Scale = (n << OUT_FRAC_BITS) / den.
  logic          sc_v;
  logic [QW-1:0] sc_q;
  logic [48:0]   sc_side;

  rsdz_div #(.QB(QW), .DW(16), .SW(49)) u_scale_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sm_v_r),
    .in_rem    ({2'b00, sm_n_r[14:1]}),
    .in_low    ({sm_n_r[0], {OUT_FRAC_BITS{1'b0}}}),
    .in_div    ({1'b0, sm_den_r}),
    .in_side   ({sm_dz_r, sm_mag_r, sm_d_r}),
    .out_valid (sc_v),
    .out_quo   (sc_q),
    .out_side  (sc_side)
  );

  // Axis magnitude times scale.
  in_t           sc_d;
  logic [15:0]   sc_mag;
  logic          sc_dz;
  logic [15:0]   ax;
  logic [15:0]   ay;
  logic          mu_v_r;
  logic [PW-1:0] mu_px_r;
  logic [PW-1:0] mu_py_r;
  logic [15:0]   mu_mag_r;
  logic          mu_sx_r;
  logic          mu_sy_r;
  logic          mu_dz_r;

  assign sc_d   = sc_side[31:0];
  assign sc_mag = sc_side[47:32];
  assign sc_dz  = sc_side[48];
  assign ax     = sc_d.stick_x[15] ? 16'(-sc_d.stick_x) : sc_d.stick_x;
  assign ay     = sc_d.stick_y[15] ? 16'(-sc_d.stick_y) : sc_d.stick_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_v_r <= 1'b0;
    end else begin
      mu_v_r <= sc_v;
    end
    mu_px_r  <= PW'(ax) * PW'(sc_q);
    mu_py_r  <= PW'(ay) * PW'(sc_q);
    mu_mag_r <= sc_mag;
    mu_sx_r  <= sc_d.stick_x[15];
    mu_sy_r  <= sc_d.stick_y[15];
    mu_dz_r  <= sc_dz;
  end

  // Divide each product by the unclipped magnitude.
  logic          dx_v;
  logic [QW-1:0] dx_q;
  logic [1:0]    dx_side;
  logic          dy_v;
  logic [QW-1:0] dy_q;
  logic          dy_side;

  rsdz_div #(.QB(QW), .DW(16), .SW(2)) u_x_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mu_v_r),
    .in_rem    (mu_px_r[PW-1:QW]),
    .in_low    (mu_px_r[QW-1:0]),
    .in_div    (mu_mag_r),
    .in_side   ({mu_dz_r, mu_sx_r}),
    .out_valid (dx_v),
    .out_quo   (dx_q),
    .out_side  (dx_side)
  );

  rsdz_div #(.QB(QW), .DW(16), .SW(1)) u_y_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mu_v_r),
    .in_rem    (mu_py_r[PW-1:QW]),
    .in_low    (mu_py_r[QW-1:0]),
    .in_div    (mu_mag_r),
    .in_side   (mu_sy_r),
    .out_valid (dy_v),
    .out_quo   (dy_q),
    .out_side  (dy_side)
  );

  // Sign, saturate and clear inside the dead zone.
  function automatic logic signed [15:0] sat_axis(input logic [16:0] q, input logic neg);
    logic signed [15:0] r;
    if (neg) begin
      r = (q > 17'd32768) ? AXIS_MIN : 16'(-q);
    end else begin
      r = (q > 17'd32767) ? AXIS_MAX : q[15:0];
    end
    return r;
  endfunction

  logic out_valid_r;
  out_t out_data_r;
  out_t out_nxt;

  always_comb begin
    out_nxt.in_dead_zone = dx_side[1];
    if (dx_side[1]) begin
      out_nxt.out_x = '0;
      out_nxt.out_y = '0;
    end else begin
      out_nxt.out_x = sat_axis(17'(dx_q), dx_side[0]);
      out_nxt.out_y = sat_axis(17'(dy_q), dy_side);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dx_v & dy_v;
    end
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // Every accepted sample yields a result after a fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(start, LAT) |-> out_valid)
    else $error("accepted sample gave no result");

  // No result appears without a sample accepted a fixed latency earlier.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result strobe without a matching sample");

  // The two axis dividers stay in lockstep.
  a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    dx_v == dy_v)
    else $error("axis dividers out of step");

  // A dead-zone result carries zero on both axes.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.in_dead_zone |-> out_data.out_x == 0 && out_data.out_y == 0)
    else $error("dead-zone result is not zero");

  // A completed register write lands in the radius.
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && paddr[2] == REG_DEAD_ZONE |=> dz_r == $past(pwdata[14:0]))
    else $error("dead-zone write lost");
`endif

endmodule

FILE: hdl/rsdz_isqrt.sv
// ----------------------------------------------------------------------------
// rsdz_isqrt
// Pipelined integer square root of a 32-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module rsdz_isqrt #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [31:0]   in_rad,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [15:0]   out_root,
  output logic [SW-1:0] out_side
);

  localparam int NS = 16;

  logic          val_r  [NS];
  logic [31:0]   rad_r  [NS];
  logic [16:0]   rem_r  [NS];
  logic [15:0]   root_r [NS];
  logic [SW-1:0] side_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic          pv;
    logic [31:0]   prad;
    logic [16:0]   prem;
    logic [15:0]   proot;
    logic [SW-1:0] pside;
    logic [18:0]   cur;
    logic [18:0]   trial;
    logic [16:0]   rem_nxt;
    logic [15:0]   root_nxt;

    // Previous stage, or the pipeline input for the first one.
    if (k == 0) begin : g_first
      assign pv    = in_valid;
      assign prad  = in_rad;
      assign prem  = '0;
      assign proot = '0;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = val_r[k-1];
      assign prad  = rad_r[k-1];
      assign prem  = rem_r[k-1];
      assign proot = root_r[k-1];
      assign pside = side_r[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
      cur   = {prem, prad[31-2*k -: 2]};
      trial = {1'b0, proot, 2'b01};
      if (cur >= trial) begin
        rem_nxt  = 17'(cur - trial);
        root_nxt = {proot[14:0], 1'b1};
      end else begin
        rem_nxt  = cur[16:0];
        root_nxt = {proot[14:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[k] <= 1'b0;
      end else begin
        val_r[k] <= pv;
      end
      rad_r[k]  <= prad;
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      side_r[k] <= pside;
    end
  end

  assign out_valid = val_r[NS-1];
  assign out_root  = root_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

FILE: hdl/rsdz_div.sv
// ----------------------------------------------------------------------------
// rsdz_div
// Pipelined restoring divider, one quotient bit per stage. The starting
// remainder must be below the divisor; the low dividend bits shift in.
// ----------------------------------------------------------------------------
module rsdz_div #(
  parameter int QB = 16,
  parameter int DW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [QB-1:0] in_low,
  input  logic [DW-1:0] in_div,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QB-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic          val_r  [QB];
  logic [DW-1:0] rem_r  [QB];
  logic [QB-1:0] low_r  [QB];
  logic [DW-1:0] div_r  [QB];
  logic [QB-1:0] quo_r  [QB];
  logic [SW-1:0] side_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic          pv;
    logic [DW-1:0] prem;
    logic [QB-1:0] plow;
    logic [DW-1:0] pdiv;
    logic [QB-1:0] pquo;
    logic [SW-1:0] pside;
    logic [DW:0]   cur;
    logic [DW-1:0] rem_nxt;
    logic [QB-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = in_rem;
      assign plow  = in_low;
      assign pdiv  = in_div;
      assign pquo  = '0;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = val_r[k-1];
      assign prem  = rem_r[k-1];
      assign plow  = low_r[k-1];
      assign pdiv  = div_r[k-1];
      assign pquo  = quo_r[k-1];
      assign pside = side_r[k-1];
    end

    // Shift in one dividend bit and subtract the divisor where it fits.
    always_comb begin
      cur     = {prem, plow[QB-1-k]};
      quo_nxt = pquo;
      if (cur >= {1'b0, pdiv}) begin
        rem_nxt          = DW'(cur - {1'b0, pdiv});
        quo_nxt[QB-1-k]  = 1'b1;
      end else begin
        rem_nxt          = cur[DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[k] <= 1'b0;
      end else begin
        val_r[k] <= pv;
      end
      rem_r[k]  <= rem_nxt;
      low_r[k]  <= plow;
      div_r[k]  <= pdiv;
      quo_r[k]  <= quo_nxt;
      side_r[k] <= pside;
    end
  end

  assign out_valid = val_r[QB-1];
  assign out_quo   = quo_r[QB-1];
  assign out_side  = side_r[QB-1];

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the radial stick dead-zone block. Directed samples
// and random bursts run through several dead-zone settings; a scoreboard predicts
// each result and compares it field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb;
  import rsdz_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 15;
  localparam int LATENCY = 21 + 2 * (FRAC + 1);

  // Predicts rescaled stick results and holds them until they leave the block.
  class stick_scoreboard;
    out_t pending[$];
    logic [14:0] radius;
    int mismatches;
    int checked;

    function new();
      radius = DZ_RESET;
      mismatches = 0;
      checked = 0;
    endfunction

    function automatic longint unsigned root_of(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function automatic logic signed [15:0] scaled_axis(longint axis, longint unsigned scl,
                                                       longint unsigned mag);
      longint unsigned q;
      longint r;
      q = ((axis < 0 ? -axis : axis) * scl) / mag;
      r = (axis < 0) ? -longint'(q) : longint'(q);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
    endfunction

    // Work out the result of one accepted sample.
    function void note_sample(in_t s);
      longint x;
      longint y;
      longint unsigned mag;
      longint unsigned mc;
      longint unsigned denom;
      longint unsigned scl;
      longint unsigned dz;
      out_t e;
      x = s.stick_x;
      y = s.stick_y;
      dz = radius;
      mag = root_of(x * x + y * y);
      e = '0;
      if (mag <= dz) begin
        e.in_dead_zone = 1'b1;
      end else begin
        mc = (mag > 32767) ? 32767 : mag;
        denom = 32767 - dz;
        scl = (denom == 0 || mc <= dz) ? 0 : ((mc - dz) << FRAC) / denom;
        e.out_x = scaled_axis(x, scl, mag);
        e.out_y = scaled_axis(y, scl, mag);
      end
      pending.push_back(e);
    endfunction

    // Compare one result beat with the oldest prediction.
    function void check_result(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result beat %h", got);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.out_x !== e.out_x || got.out_y !== e.out_y ||
          got.in_dead_zone !== e.in_dead_zone) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected x=%0d y=%0d dz=%b, got x=%0d y=%0d dz=%b",
                   e.out_x, e.out_y, e.in_dead_zone,
                   got.out_x, got.out_y, got.in_dead_zone);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_t         in_data;
  logic        out_valid;
  out_t        out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  stick_scoreboard board;
  int sent;

  radial_stick_dead_zone_top #(.OUT_FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Accept samples and check results at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        board.note_sample(in_data);
        sent++;
      end
      if (out_valid) board.check_result(out_data);
    end
  end

  // Write the dead-zone radius: setup beat, then access beat.
  task automatic write_radius(logic [14:0] r);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_DEAD_ZONE, 2'b00};
    pwdata <= {17'd0, r};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.radius = r;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Present one sample; start stays high if the next call follows at once.
  task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y);
    @(negedge clk);
    start <= 1'b1;
    in_data <= '{stick_x: x, stick_y: y};
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Let the pipeline drain before touching the register.
  task automatic drain();
    pause(0);
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // Random samples in bursts: fully random, near the radius on an axis, near full scale, and near the center.
  task automatic random_samples(int count);
    int left;
    int burst;
    int kind;
    int ang;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 30);
      if (burst > left) burst = left;
      for (int i = 0; i < burst; i++) begin
        kind = $urandom_range(0, 3);
        if (kind == 0) begin
          send_sample(16'($urandom), 16'($urandom));
        end else if (kind == 1) begin
          // Along an axis near the radius.
          ang = int'(board.radius) + $urandom_range(0, 6) - 3;
          if (ang > 32767) ang = 32767;
          if ($urandom_range(0, 1)) send_sample($urandom_range(0, 1) ? 16'(ang) : 16'(-ang),
                                                16'sd0);
          else send_sample(16'sd0, $urandom_range(0, 1) ? 16'(ang) : 16'(-ang));
        end else if (kind == 2) begin
          send_sample($urandom_range(0, 1) ? 16'(16'sh7FFF - $urandom_range(0, 4000))
                                           : 16'(16'sh8000 + $urandom_range(0, 4000)),
                      $urandom_range(0, 1) ? 16'(16'sh7FFF - $urandom_range(0, 4000))
                                           : 16'(16'sh8000 + $urandom_range(0, 4000)));
        end else begin
          send_sample($signed(16'($urandom_range(0, 16000))) - 16'sd8000,
                      $signed(16'($urandom_range(0, 16000))) - 16'sd8000);
        end
      end
      left -= burst;
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 8));
    end
  endtask

  initial begin
    logic [14:0] radii[5];
    board = new();
    sent = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: center, axis extremes, corners, reset radius edge, small and mixed values.
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sh7FFF, 16'sd0);
    send_sample(16'sh8000, 16'sd0);
    send_sample(16'sd0, 16'sh7FFF);
    send_sample(16'sd0, 16'sh8000);
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sd7849, 16'sd0);
    send_sample(16'sd7850, 16'sd0);
    send_sample(16'sd0, -16'sd7850);
    send_sample(-16'sd1, 16'sd1);
    send_sample(16'sh5555, 16'shAAAA);
    // Sender waits until every result is back.
    drain();

    radii = '{15'd0, 15'd32766, 15'd32767, 15'd1000, 15'd7849};
    foreach (radii[k]) begin
      write_radius(radii[k]);
      send_sample(16'sh7FFF, 16'sh7FFF);
      send_sample(16'sh8000, 16'sh8000);
      send_sample(16'sh7FFF, 16'sd0);
      send_sample(16'sd1, 16'sd0);
      random_samples(100);
      drain();
    end

    $display("Covered %0d samples over radii 0, 1000, 7849, 32766 and 32767,", sent);
    $display("including axis extremes, corners and the dead-zone boundary.");
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/rsdz_pkg.sv
hdl/rsdz_isqrt.sv
hdl/rsdz_div.sv
hdl/radial_stick_dead_zone_top.sv
tb/tb.sv
